// ===== src/rpp_pkg.sv =====
// Shared types, widths and helper functions for the pivot rotation block.
// Used by the channel interfaces, the sine/cosine unit, the rotation stage
// and the top level.
`default_nettype none

package rpp_pkg;

    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_W > ANGLE_W) ? COORD_W : ANGLE_W;

    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    localparam int PHASE_W   = 32;
    localparam int TRIG_FRAC = 30;
    localparam int T_W       = TRIG_FRAC + 1;
    localparam int TRIG_W    = T_W + 1;
    localparam int ACC_W     = 33;
    localparam int PROD_W    = ACC_W + 1 + T_W + 1;
    localparam int STEP_W    = 4;
    localparam int STEP_LAST = 8;
    localparam int COEF_TOP  = 7;

    localparam int ROT_W  = COORD_W + 2;
    localparam int LO_W   = ROT_W / 2;
    localparam int HI_W   = ROT_W - LO_W;
    localparam int HI_PW  = HI_W + TRIG_W + 1;
    localparam int LO_PW  = LO_W + 1 + TRIG_W + 1;
    localparam int SUM_W  = HI_PW + LO_W + 1;

    localparam int PIPE_DEPTH = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef struct packed {
        trig_t sin_v;
        trig_t cos_v;
    } sincos_t;

    typedef struct packed {
        logic mul_en;
        logic cmb_en;
    } rot_ctrl_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Z = CFG_IDX_W'(5);

    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << TRIG_FRAC;

    localparam logic signed [ROT_W:0] SAT_HI = (ROT_W+1)'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [ROT_W:0] SAT_LO = -SAT_HI - (ROT_W+1)'(1);

    // Odd polynomial for a quarter sine wave in Q2.30, highest term last.
    function automatic logic signed [ACC_W-1:0] sine_coef(input logic [2:0] idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            3'd0:    c = ACC_W'(1686629713);
            3'd1:    c = ACC_W'(-693598668);
            3'd2:    c = ACC_W'(85569305);
            3'd3:    c = ACC_W'(-5026995);
            3'd4:    c = ACC_W'(172272);
            3'd5:    c = ACC_W'(-3864);
            3'd6:    c = ACC_W'(61);
            default: c = ACC_W'(-1);
        endcase
        return c;
    endfunction

    // Binary angle placed in a full-turn phase; cosine is a quarter turn ahead.
    function automatic logic [PHASE_W-1:0] angle_phase(input angle_t a, input logic cos_sel);
        logic [PHASE_W-1:0] p;
        p = {a, {(PHASE_W-ANGLE_W){1'b0}}};
        if (cos_sel)
        begin
            p = p + QUARTER_TURN;
        end
        return p;
    endfunction

    function automatic coord_t saturate(input logic signed [ROT_W:0] v);
        coord_t r;
        if (v > SAT_HI)
        begin
            r = coord_t'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = coord_t'(SAT_LO);
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/rpp_point_if.sv =====
// Input channel carrying one point per request.
// Depends on rpp_pkg for the coordinate type.
`default_nettype none

interface rpp_point_if;
    logic            valid;
    logic            ready;
    rpp_pkg::coord_t point_x;
    rpp_pkg::coord_t point_y;
    rpp_pkg::coord_t point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

`default_nettype wire

// ===== src/rpp_rotated_if.sv =====
// Output channel carrying one rotated point per request.
// Depends on rpp_pkg for the coordinate type.
`default_nettype none

interface rpp_rotated_if;
    logic            valid;
    logic            ready;
    rpp_pkg::coord_t rotated_x;
    rpp_pkg::coord_t rotated_y;
    rpp_pkg::coord_t rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink (input valid, input rotated_x, input rotated_y, input rotated_z,
                  output ready);
endinterface

`default_nettype wire

// ===== src/rpp_cfg_if.sv =====
// Configuration write channel: register index and write data per request.
// Depends on rpp_pkg for the index and data widths.
`default_nettype none

interface rpp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rpp_pkg::CFG_IDX_W-1:0]     index;
    logic [rpp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rpp_trig.sv =====
// Sine and cosine of the three configured angles, computed by one shared
// multiplier running Horner's rule. Depends on rpp_pkg.
`default_nettype none

module rpp_trig (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rpp_pkg::angle_t             angle [rpp_pkg::AXES],
    input  wire logic [rpp_pkg::AXES-1:0]    angle_wr,
    output rpp_pkg::sincos_t                 sc [rpp_pkg::AXES],
    output logic                             busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    localparam logic [rpp_pkg::T_W-1:0] T_ONE = rpp_pkg::T_W'(1) << rpp_pkg::TRIG_FRAC;
    localparam logic signed [rpp_pkg::PROD_W-1:0] RND_HALF =
        rpp_pkg::PROD_W'(1) <<< (rpp_pkg::TRIG_FRAC - 1);
    localparam logic signed [rpp_pkg::PROD_W-1:0] RND_ONE =
        rpp_pkg::PROD_W'(1) <<< rpp_pkg::TRIG_FRAC;

    logic [1:0]                          state_reg, state_next;
    logic [rpp_pkg::AXES-1:0]            pending_reg, pending_next;
    logic [rpp_pkg::AXIS_W-1:0]          axis_reg, axis_next;
    logic                                cos_sel_reg, cos_sel_next;
    logic [rpp_pkg::STEP_W-1:0]          step_reg, step_next;

    logic [rpp_pkg::T_W-1:0]             t_reg, t2_reg;
    logic signed [rpp_pkg::ACC_W-1:0]    acc_reg;
    logic                                neg_reg;
    rpp_pkg::trig_t                      sin_reg [rpp_pkg::AXES];
    rpp_pkg::trig_t                      cos_reg [rpp_pkg::AXES];

    logic [rpp_pkg::PHASE_W-1:0]         phase;
    logic [rpp_pkg::T_W-1:0]             t_frac, t_load;
    logic signed [rpp_pkg::ACC_W:0]      op_a;
    logic signed [rpp_pkg::T_W:0]        op_b;
    logic signed [rpp_pkg::PROD_W-1:0]   prod, rnd;
    logic [2:0]                          coef_idx;
    logic [rpp_pkg::T_W-1:0]             mag;
    rpp_pkg::trig_t                      result;
    logic                                store;
    logic [rpp_pkg::AXIS_W-1:0]          pick;

    always_comb
    begin
        phase  = rpp_pkg::angle_phase(angle[axis_reg], cos_sel_reg);
        t_frac = {1'b0, phase[rpp_pkg::TRIG_FRAC-1:0]};
        t_load = phase[rpp_pkg::TRIG_FRAC] ? (T_ONE - t_frac) : t_frac;
    end

    always_comb
    begin
        if (step_reg == '0)
        begin
            op_a = (rpp_pkg::ACC_W+1)'(t_reg);
        end
        else
        begin
            op_a = (rpp_pkg::ACC_W+1)'(acc_reg);
        end
        if (step_reg == '0 || step_reg == rpp_pkg::STEP_W'(rpp_pkg::STEP_LAST))
        begin
            op_b = {1'b0, t_reg};
        end
        else
        begin
            op_b = {1'b0, t2_reg};
        end
        prod     = op_a * op_b;
        rnd      = (prod + RND_HALF) >>> rpp_pkg::TRIG_FRAC;
        coef_idx = 3'(rpp_pkg::STEP_W'(rpp_pkg::COEF_TOP) - step_reg);
        if (rnd < 0)
        begin
            mag = '0;
        end
        else if (rnd > RND_ONE)
        begin
            mag = T_ONE;
        end
        else
        begin
            mag = rnd[rpp_pkg::T_W-1:0];
        end
        result = neg_reg ? -rpp_pkg::trig_t'({1'b0, mag}) : rpp_pkg::trig_t'({1'b0, mag});
    end

    always_comb
    begin
        pick = rpp_pkg::AXIS_W'(rpp_pkg::AXES - 1);
        for (int i = rpp_pkg::AXES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                pick = rpp_pkg::AXIS_W'(i);
            end
        end

        state_next   = state_reg;
        pending_next = pending_reg | angle_wr;
        axis_next    = axis_reg;
        cos_sel_next = cos_sel_reg;
        step_next    = step_reg;
        store        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg != '0)
                begin
                    axis_next    = pick;
                    pending_next = (pending_reg & ~(rpp_pkg::AXES'(1) << pick)) | angle_wr;
                    cos_sel_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == rpp_pkg::STEP_W'(rpp_pkg::STEP_LAST))
                begin
                    store = 1'b1;
                    if (!cos_sel_reg)
                    begin
                        cos_sel_next = 1'b1;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + rpp_pkg::STEP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= '1;
            axis_reg    <= '0;
            cos_sel_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            axis_reg    <= axis_next;
            cos_sel_reg <= cos_sel_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            t_reg   <= t_load;
            neg_reg <= phase[rpp_pkg::PHASE_W-1];
        end
        if (state_reg == ST_MUL)
        begin
            if (step_reg == '0)
            begin
                t2_reg  <= rnd[rpp_pkg::T_W-1:0];
                acc_reg <= rpp_pkg::sine_coef(coef_idx);
            end
            else
            begin
                acc_reg <= rpp_pkg::sine_coef(coef_idx) + rnd[rpp_pkg::ACC_W-1:0];
            end
        end
        for (int i = 0; i < rpp_pkg::AXES; i++)
        begin
            if (store && axis_reg == rpp_pkg::AXIS_W'(i))
            begin
                if (cos_sel_reg)
                begin
                    cos_reg[i] <= result;
                end
                else
                begin
                    sin_reg[i] <= result;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < rpp_pkg::AXES; i++)
        begin
            sc[i].sin_v = sin_reg[i];
            sc[i].cos_v = cos_reg[i];
        end
    end

    assign busy = (state_reg != ST_IDLE) || (pending_reg != '0);

endmodule

`default_nettype wire

// ===== src/rpp_rot.sv =====
// One plane rotation as two pipeline stages: split partial products, then
// recombination with round to nearest. Depends on rpp_pkg.
`default_nettype none

module rpp_rot (
    input  wire logic               clk,
    input  wire rpp_pkg::rot_ctrl_t ctrl,
    input  wire rpp_pkg::rot_t      a,
    input  wire rpp_pkg::rot_t      b,
    input  wire rpp_pkg::sincos_t   sc,
    output rpp_pkg::rot_t           p,
    output rpp_pkg::rot_t           q
);

    localparam logic signed [rpp_pkg::SUM_W-1:0] SUM_HALF =
        rpp_pkg::SUM_W'(1) <<< (rpp_pkg::TRIG_FRAC - 1);

    logic signed [rpp_pkg::HI_W-1:0]   ah, bh;
    logic signed [rpp_pkg::LO_W:0]     al, bl;
    logic signed [rpp_pkg::HI_PW-1:0]  hi_p_next, hi_q_next, hi_p_reg, hi_q_reg;
    logic signed [rpp_pkg::LO_PW-1:0]  lo_p_next, lo_q_next, lo_p_reg, lo_q_reg;
    logic signed [rpp_pkg::SUM_W-1:0]  sum_p, sum_q;
    rpp_pkg::rot_t                     p_reg, q_reg;

    always_comb
    begin
        ah = a[rpp_pkg::ROT_W-1:rpp_pkg::LO_W];
        bh = b[rpp_pkg::ROT_W-1:rpp_pkg::LO_W];
        al = {1'b0, a[rpp_pkg::LO_W-1:0]};
        bl = {1'b0, b[rpp_pkg::LO_W-1:0]};
        hi_p_next = ah * sc.cos_v - bh * sc.sin_v;
        hi_q_next = ah * sc.sin_v + bh * sc.cos_v;
        lo_p_next = al * sc.cos_v - bl * sc.sin_v;
        lo_q_next = al * sc.sin_v + bl * sc.cos_v;
    end

    always_comb
    begin
        sum_p = (rpp_pkg::SUM_W'(hi_p_reg) <<< rpp_pkg::LO_W) + rpp_pkg::SUM_W'(lo_p_reg)
                + SUM_HALF;
        sum_q = (rpp_pkg::SUM_W'(hi_q_reg) <<< rpp_pkg::LO_W) + rpp_pkg::SUM_W'(lo_q_reg)
                + SUM_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            hi_p_reg <= hi_p_next;
            hi_q_reg <= hi_q_next;
            lo_p_reg <= lo_p_next;
            lo_q_reg <= lo_q_next;
        end
        if (ctrl.cmb_en)
        begin
            p_reg <= sum_p[rpp_pkg::TRIG_FRAC +: rpp_pkg::ROT_W];
            q_reg <= sum_q[rpp_pkg::TRIG_FRAC +: rpp_pkg::ROT_W];
        end
    end

    assign p = p_reg;
    assign q = q_reg;

endmodule

`default_nettype wire

// ===== src/rotate_point_about_pivot_xyz.sv =====
// Rotates each point about a configured pivot, X then Y then Z axis.
// Depends on rpp_pkg, the three channel interfaces, rpp_trig and rpp_rot.
//
// Usage: points enter on the point channel and leave on the rotated channel,
// one result per request, in order. Coordinates are signed Q16.16; angles are
// binary angles with 65536 per turn. The cfg channel writes angle_x, angle_y,
// angle_z (indexes 0 to 2) and pivot_x, pivot_y, pivot_z (indexes 3 to 5);
// other indexes are ignored. The cfg channel is always ready and should only
// be used while no point is in flight.
// One point is taken per cycle while the output does not stall and no sine and
// cosine update is running. Eight register stages: pivot subtraction, two per
// axis rotation (partial products, then recombination) and output saturation.
// Sine and cosine come from one shared multiplier: each angle write keeps the
// point channel not ready until its sine and cosine are recomputed, and after
// reset the three angles are evaluated first. A stall on the output freezes only
// the stages that hold data, so bubbles are squeezed out and nothing is lost.
`default_nettype none

module rotate_point_about_pivot_xyz (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rpp_point_if.sink       point,
    rpp_rotated_if.source   rotated,
    rpp_cfg_if.sink         cfg
);

    localparam int STG_DIFF = 0;
    localparam int STG_XM   = 1;
    localparam int STG_XC   = 2;
    localparam int STG_YM   = 3;
    localparam int STG_YC   = 4;
    localparam int STG_ZM   = 5;
    localparam int STG_ZC   = 6;
    localparam int STG_OUT  = 7;

    rpp_pkg::angle_t                   angle_reg [rpp_pkg::AXES];
    rpp_pkg::coord_t                   pivot_reg [rpp_pkg::AXES];
    logic [rpp_pkg::AXES-1:0]          angle_wr;
    logic                              cfg_fire;
    rpp_pkg::sincos_t                  sc [rpp_pkg::AXES];
    logic                              trig_busy;

    logic [rpp_pkg::PIPE_DEPTH-1:0]    valid_reg;
    logic [rpp_pkg::PIPE_DEPTH-1:0]    en;
    logic                              in_fire;

    rpp_pkg::rot_t                     x0_reg, y0_reg, z0_reg;
    rpp_pkg::rot_t                     x1_reg, x2_reg, y3_reg, y4_reg, z5_reg, z6_reg;
    rpp_pkg::rot_t                     y2, z2, x4, z4, x6, y6;
    rpp_pkg::coord_t                   out_x_reg, out_y_reg, out_z_reg;
    rpp_pkg::rot_ctrl_t                ctrl_x, ctrl_y, ctrl_z;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    assign angle_wr[rpp_pkg::AXIS_X] = cfg_fire && (cfg.index == rpp_pkg::CFG_ANGLE_X);
    assign angle_wr[rpp_pkg::AXIS_Y] = cfg_fire && (cfg.index == rpp_pkg::CFG_ANGLE_Y);
    assign angle_wr[rpp_pkg::AXIS_Z] = cfg_fire && (cfg.index == rpp_pkg::CFG_ANGLE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rpp_pkg::AXES; i++)
            begin
                angle_reg[i] <= '0;
                pivot_reg[i] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                rpp_pkg::CFG_ANGLE_X: angle_reg[rpp_pkg::AXIS_X] <= cfg.data[rpp_pkg::ANGLE_W-1:0];
                rpp_pkg::CFG_ANGLE_Y: angle_reg[rpp_pkg::AXIS_Y] <= cfg.data[rpp_pkg::ANGLE_W-1:0];
                rpp_pkg::CFG_ANGLE_Z: angle_reg[rpp_pkg::AXIS_Z] <= cfg.data[rpp_pkg::ANGLE_W-1:0];
                rpp_pkg::CFG_PIVOT_X: pivot_reg[rpp_pkg::AXIS_X] <= cfg.data[rpp_pkg::COORD_W-1:0];
                rpp_pkg::CFG_PIVOT_Y: pivot_reg[rpp_pkg::AXIS_Y] <= cfg.data[rpp_pkg::COORD_W-1:0];
                rpp_pkg::CFG_PIVOT_Z: pivot_reg[rpp_pkg::AXIS_Z] <= cfg.data[rpp_pkg::COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rpp_trig u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle    (angle_reg),
        .angle_wr (angle_wr),
        .sc       (sc),
        .busy     (trig_busy)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[STG_OUT] = !valid_reg[STG_OUT] || rotated.ready;
        for (int i = rpp_pkg::PIPE_DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign point.ready = en[STG_DIFF] && !trig_busy;
    assign in_fire     = point.valid && point.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[STG_DIFF])
            begin
                valid_reg[STG_DIFF] <= in_fire;
            end
            for (int i = 1; i < rpp_pkg::PIPE_DEPTH; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_DIFF])
        begin
            x0_reg <= rpp_pkg::ROT_W'(point.point_x)
                      - rpp_pkg::ROT_W'(pivot_reg[rpp_pkg::AXIS_X]);
            y0_reg <= rpp_pkg::ROT_W'(point.point_y)
                      - rpp_pkg::ROT_W'(pivot_reg[rpp_pkg::AXIS_Y]);
            z0_reg <= rpp_pkg::ROT_W'(point.point_z)
                      - rpp_pkg::ROT_W'(pivot_reg[rpp_pkg::AXIS_Z]);
        end
        if (en[STG_XM])
        begin
            x1_reg <= x0_reg;
        end
        if (en[STG_XC])
        begin
            x2_reg <= x1_reg;
        end
        if (en[STG_YM])
        begin
            y3_reg <= y2;
        end
        if (en[STG_YC])
        begin
            y4_reg <= y3_reg;
        end
        if (en[STG_ZM])
        begin
            z5_reg <= z4;
        end
        if (en[STG_ZC])
        begin
            z6_reg <= z5_reg;
        end
        if (en[STG_OUT])
        begin
            out_x_reg <= rpp_pkg::saturate((rpp_pkg::ROT_W+1)'(x6)
                         + (rpp_pkg::ROT_W+1)'(pivot_reg[rpp_pkg::AXIS_X]));
            out_y_reg <= rpp_pkg::saturate((rpp_pkg::ROT_W+1)'(y6)
                         + (rpp_pkg::ROT_W+1)'(pivot_reg[rpp_pkg::AXIS_Y]));
            out_z_reg <= rpp_pkg::saturate((rpp_pkg::ROT_W+1)'(z6_reg)
                         + (rpp_pkg::ROT_W+1)'(pivot_reg[rpp_pkg::AXIS_Z]));
        end
    end

    assign ctrl_x = '{mul_en: en[STG_XM], cmb_en: en[STG_XC]};
    assign ctrl_y = '{mul_en: en[STG_YM], cmb_en: en[STG_YC]};
    assign ctrl_z = '{mul_en: en[STG_ZM], cmb_en: en[STG_ZC]};

    rpp_rot u_rot_x (
        .clk  (clk),
        .ctrl (ctrl_x),
        .a    (y0_reg),
        .b    (z0_reg),
        .sc   (sc[rpp_pkg::AXIS_X]),
        .p    (y2),
        .q    (z2)
    );

    rpp_rot u_rot_y (
        .clk  (clk),
        .ctrl (ctrl_y),
        .a    (x2_reg),
        .b    (z2),
        .sc   (sc[rpp_pkg::AXIS_Y]),
        .p    (x4),
        .q    (z4)
    );

    rpp_rot u_rot_z (
        .clk  (clk),
        .ctrl (ctrl_z),
        .a    (x4),
        .b    (y4_reg),
        .sc   (sc[rpp_pkg::AXIS_Z]),
        .p    (x6),
        .q    (y6)
    );

    assign rotated.valid     = valid_reg[STG_OUT];
    assign rotated.rotated_x = out_x_reg;
    assign rotated.rotated_y = out_y_reg;
    assign rotated.rotated_z = out_z_reg;

    a_angle_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && (cfg.index == rpp_pkg::CFG_ANGLE_X
            || cfg.index == rpp_pkg::CFG_ANGLE_Y || cfg.index == rpp_pkg::CFG_ANGLE_Z))
        |=> trig_busy)
        else $error("Angle write did not start a sine/cosine update.");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> valid_reg[STG_DIFF])
        else $error("Accepted point did not enter the first stage.");

    a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STG_YC] && en[STG_ZM]) |=> valid_reg[STG_ZM])
        else $error("Point lost between the Y and Z rotations.");

endmodule

`default_nettype wire
